FILE: hdl/woc_pkg.sv
// Shared types, constants and helper functions for the window occlusion cull block.
package woc_pkg;

    // Default number of covering rectangles held in the table.
    localparam int COVER_DEPTH_DEF = 16;

    // Width of the signed coordinate math: decorated and clipped edges reach
    // from -33791 up to 66557, and covering edges up to 131071 + 32767.
    localparam int COORD_W = 19;

    typedef logic signed [COORD_W-1:0] coord_t;

    // One stored covering rectangle.
    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [16:0]        w;
        logic [16:0]        h;
    } cover_entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the accepted item
        logic calc;    // decorate and clip, restart the table search
        logic scan;    // walk the coverage table
        logic finish;  // settle the result and update the table
        logic emit;    // move the result into the output register
    } woc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } woc_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_SCAN,
        ST_RESULT
    } woc_state_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_AREA_X       = 3'd0,
        REG_AREA_Y       = 3'd1,
        REG_AREA_WIDTH   = 3'd2,
        REG_AREA_HEIGHT  = 3'd3,
        REG_SHADOW_SIZE  = 3'd4,
        REG_TITLE_HEIGHT = 3'd5
    } woc_reg_t;

    function automatic coord_t sx16(input logic [15:0] v);
        return {{(COORD_W-16){v[15]}}, v};
    endfunction

    function automatic coord_t zx15(input logic [14:0] v);
        return {{(COORD_W-15){1'b0}}, v};
    endfunction

    function automatic coord_t zx10(input logic [9:0] v);
        return {{(COORD_W-10){1'b0}}, v};
    endfunction

    function automatic coord_t zx17(input logic [16:0] v);
        return {{(COORD_W-17){1'b0}}, v};
    endfunction

endpackage

FILE: hdl/window_occlusion_cull.sv
// Top level of the window occlusion cull block: stream ports, register port, core.
// An accepted item goes through the states CALC, SCAN and RESULT; in SCAN the table walk
// searches the stored covering rectangles, at most COVER_DEPTH of them, and reads one entry a cycle.
// No new item is taken until the item has left RESULT, and the finished result waits
// in RESULT until the output register is free or being taken.
// A new item is taken while the previous result still waits in the output register.
// Reset (rst_n, asynchronous, active low) empties the table, zeroes the configuration
// registers and leaves the output register empty.
module window_occlusion_cull #(
    parameter int COVER_DEPTH = woc_pkg::COVER_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input window items.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata from bit 0: win_x[15:0], win_y[31:16], win_width[46:32],
    // win_height[61:47], transformed[62], visible[63], opaque[64], zeros up to 71.
    input  logic [71:0] s_tdata,
    // s_tuser from bit 0: frame_start.
    input  logic [0:0]  s_tuser,
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata from bit 0: occluded, zeros up to 7.
    output logic [7:0]  m_tdata,
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import woc_pkg::*;

    // Configuration registers. Writes land on the access cycle of a write.
    logic signed [15:0] area_x_reg, area_y_reg;
    logic [14:0]        area_width_reg, area_height_reg;
    logic [9:0]         shadow_size_reg, title_height_reg;
    logic               wr_en;
    woc_reg_t           reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = woc_reg_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_x_reg       <= '0;
            area_y_reg       <= '0;
            area_width_reg   <= '0;
            area_height_reg  <= '0;
            shadow_size_reg  <= '0;
            title_height_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_AREA_X:       area_x_reg       <= pwdata[15:0];
                REG_AREA_Y:       area_y_reg       <= pwdata[15:0];
                REG_AREA_WIDTH:   area_width_reg   <= pwdata[14:0];
                REG_AREA_HEIGHT:  area_height_reg  <= pwdata[14:0];
                REG_SHADOW_SIZE:  shadow_size_reg  <= pwdata[9:0];
                REG_TITLE_HEIGHT: title_height_reg <= pwdata[9:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read back; signed registers come back sign extended, unused addresses read zero.
    always_comb
    begin
        case (reg_sel)
            REG_AREA_X:       prdata = {{16{area_x_reg[15]}}, area_x_reg};
            REG_AREA_Y:       prdata = {{16{area_y_reg[15]}}, area_y_reg};
            REG_AREA_WIDTH:   prdata = {17'd0, area_width_reg};
            REG_AREA_HEIGHT:  prdata = {17'd0, area_height_reg};
            REG_SHADOW_SIZE:  prdata = {22'd0, shadow_size_reg};
            REG_TITLE_HEIGHT: prdata = {22'd0, title_height_reg};
            default:          prdata = '0;
        endcase
    end

    // The controller sequences each item; the datapath does all arithmetic and
    // holds the coverage table.
    woc_cmd_t    cmd;
    woc_status_t status;

    woc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    woc_datapath #(
        .COVER_DEPTH (COVER_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .frame_start  (s_tuser[0]),
        .win_x        (s_tdata[15:0]),
        .win_y        (s_tdata[31:16]),
        .win_width    (s_tdata[46:32]),
        .win_height   (s_tdata[61:47]),
        .transformed  (s_tdata[62]),
        .visible      (s_tdata[63]),
        .opaque       (s_tdata[64]),
        .area_x       (area_x_reg),
        .area_y       (area_y_reg),
        .area_width   (area_width_reg),
        .area_height  (area_height_reg),
        .shadow_size  (shadow_size_reg),
        .title_height (title_height_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_data     (m_tdata)
    );

    // Only one item is in flight: after an accept, input stays closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // A result only moves into the output register when that register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result emitted over an untaken result");

    // Emitting a result hands a valid output and reopens the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (m_tvalid && s_tready))
        else $error("emit did not present a result and reopen input");

    // The controller never issues two commands in the same cycle except
    // scan together with finish.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.calc, cmd.scan, cmd.emit}))
        else $error("conflicting datapath commands");

endmodule

FILE: hdl/woc_ctrl.sv
// Controller state machine that sequences one window item through the datapath.
module woc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  woc_pkg::woc_status_t status,
    output woc_pkg::woc_cmd_t    cmd
);
    import woc_pkg::*;

    woc_state_t state_reg;
    woc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/woc_datapath.sv
// Datapath: item registers, decorate and clip, coverage table and output register.
module woc_datapath #(
    parameter int COVER_DEPTH = woc_pkg::COVER_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  woc_pkg::woc_cmd_t    cmd,
    output woc_pkg::woc_status_t status,
    input  logic                 frame_start,
    input  logic signed [15:0]   win_x,
    input  logic signed [15:0]   win_y,
    input  logic [14:0]          win_width,
    input  logic [14:0]          win_height,
    input  logic                 transformed,
    input  logic                 visible,
    input  logic                 opaque,
    input  logic signed [15:0]   area_x,
    input  logic signed [15:0]   area_y,
    input  logic [14:0]          area_width,
    input  logic [14:0]          area_height,
    input  logic [9:0]           shadow_size,
    input  logic [9:0]           title_height,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_data
);
    import woc_pkg::*;

    localparam int CW = $clog2(COVER_DEPTH + 1);
    localparam int IW = (COVER_DEPTH > 1) ? $clog2(COVER_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(COVER_DEPTH);

    // Captured item.
    logic signed [15:0] wx_reg, wy_reg;
    logic [14:0]        ww_reg, wh_reg;
    logic               tr_reg, vis_reg, op_reg;

    // Clipped rectangle, candidate entry and early decision.
    coord_t       cl_reg, ct_reg, cr_reg, cb_reg;
    cover_entry_t ent_reg;
    logic         early_reg, early_occ_reg;

    // Coverage table.
    cover_entry_t mem [COVER_DEPTH];
    cover_entry_t rd_data_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] issue_reg;
    logic          pend_reg;

    logic occ_reg;
    logic out_valid_reg;
    logic [7:0] out_data_reg;

    // Decorate and clip.
    coord_t dl_c, dt_c, dr_c, db_c, ar_c, ab_c;
    coord_t cl_c, ct_c, cr_c, cb_c, top_c, h_c;
    logic   empty_c;
    cover_entry_t ent_c;

    always_comb
    begin
        dl_c = sx16(wx_reg);
        dt_c = sx16(wy_reg) - zx10(title_height);
        dr_c = sx16(wx_reg) + zx15(ww_reg) + zx10(shadow_size);
        db_c = sx16(wy_reg) + zx15(wh_reg) + zx10(shadow_size);
        ar_c = sx16(area_x) + zx15(area_width);
        ab_c = sx16(area_y) + zx15(area_height);
        cl_c = (dl_c > sx16(area_x)) ? dl_c : sx16(area_x);
        ct_c = (dt_c > sx16(area_y)) ? dt_c : sx16(area_y);
        cr_c = (dr_c < ar_c) ? dr_c : ar_c;
        cb_c = (db_c < ab_c) ? db_c : ab_c;
        empty_c = !((cl_c < cr_c) && (ct_c < cb_c));
        // A top below the 16-bit range is pinned there, keeping the bottom edge.
        top_c = (dt_c < sx16(16'h8000)) ? sx16(16'h8000) : dt_c;
        h_c   = db_c - top_c;
        ent_c.left = wx_reg;
        ent_c.top  = top_c[15:0];
        ent_c.w    = {2'b00, ww_reg} + {7'd0, shadow_size};
        ent_c.h    = h_c[16:0];
    end

    // Containment test against the entry read last cycle.
    coord_t e_left_c, e_top_c;
    logic   hit_c, rd_en_c;

    always_comb
    begin
        e_left_c = sx16(rd_data_reg.left);
        e_top_c  = sx16(rd_data_reg.top);
        hit_c = pend_reg
            && (cl_reg >= e_left_c) && (cr_reg <= e_left_c + zx17(rd_data_reg.w))
            && (ct_reg >= e_top_c)  && (cb_reg <= e_top_c + zx17(rd_data_reg.h));
        rd_en_c = cmd.scan && !early_reg && !hit_c && (issue_reg != count_reg);
        status.scan_done = early_reg || hit_c || (issue_reg == count_reg);
        status.out_free  = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            wx_reg  <= win_x;
            wy_reg  <= win_y;
            ww_reg  <= win_width;
            wh_reg  <= win_height;
            tr_reg  <= transformed;
            vis_reg <= visible;
            op_reg  <= opaque;
        end
        if (cmd.calc)
        begin
            cl_reg        <= cl_c;
            ct_reg        <= ct_c;
            cr_reg        <= cr_c;
            cb_reg        <= cb_c;
            ent_reg       <= ent_c;
            early_reg     <= tr_reg || !vis_reg || empty_c;
            early_occ_reg <= !tr_reg;
        end
        if (rd_en_c)
        begin
            rd_data_reg <= mem[issue_reg[IW-1:0]];
        end
        if (cmd.finish)
        begin
            occ_reg <= early_reg ? early_occ_reg : hit_c;
            if (!early_reg && !hit_c && op_reg && (count_reg < DEPTH_C))
            begin
                mem[count_reg[IW-1:0]] <= ent_reg;
            end
        end
        if (cmd.emit)
        begin
            out_data_reg <= {7'd0, occ_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load && frame_start)
            begin
                count_reg <= '0;
            end
            else if (cmd.finish && !early_reg && !hit_c && op_reg && (count_reg < DEPTH_C))
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.calc)
            begin
                issue_reg <= '0;
                pend_reg  <= 1'b0;
            end
            else
            begin
                if (rd_en_c)
                begin
                    issue_reg <= issue_reg + 1'b1;
                end
                pend_reg <= rd_en_c;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: bench/woc_occlusion_checker.sv
// Checker for the window occlusion cull block: predicts each occlusion flag and compares.
`timescale 1ns / 1ps

module woc_occlusion_checker #(
    parameter int COVER_DEPTH = woc_pkg::COVER_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // s_tdata from bit 0: win_x, win_y, win_width, win_height, transformed, visible, opaque.
    input  logic [71:0] s_tdata,
    // s_tuser from bit 0: frame_start.
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata from bit 0: occluded.
    input  logic [7:0]  m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending,
    output int          result_count,
    output int          occluded_count
);

    import woc_pkg::*;

    // Display area and decoration as last written over the register port.
    logic signed [15:0] disp_x;
    logic signed [15:0] disp_y;
    logic [14:0]        disp_w;
    logic [14:0]        disp_h;
    logic [9:0]         shadow;
    logic [9:0]         titlebar;

    // Covering rectangles of the current frame.
    logic signed [15:0] cov_left [COVER_DEPTH];
    logic signed [15:0] cov_top  [COVER_DEPTH];
    logic [16:0]        cov_w    [COVER_DEPTH];
    logic [16:0]        cov_h    [COVER_DEPTH];
    int                 cov_count;

    logic               expected_occluded [$];
    logic               predicted;
    logic               wanted;
    woc_reg_t           reg_sel;

    task automatic predict_occlusion(input logic [71:0] d, input logic fs, output logic occ);
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        int wx, wy, ww, wh;
        int dl, dt, dr, db;
        int cl, ct, cr, cb;
        int ax, ay, cvl, cvt, cvw, cvh, top, i;
        logic hit;
        sx = d[15:0];
        sy = d[31:16];
        wx = int'(sx);
        wy = int'(sy);
        ww = int'(d[46:32]);
        wh = int'(d[61:47]);
        ax = int'(disp_x);
        ay = int'(disp_y);
        hit = 1'b0;
        if (fs)
            cov_count = 0;
        if (d[62]) begin
            occ = 1'b0;
        end else if (!d[63]) begin
            occ = 1'b1;
        end else begin
            dl = wx;
            dt = wy - int'(titlebar);
            dr = wx + ww + int'(shadow);
            db = wy + wh + int'(shadow);
            cl = (dl > ax) ? dl : ax;
            ct = (dt > ay) ? dt : ay;
            cr = (dr < ax + int'(disp_w)) ? dr : ax + int'(disp_w);
            cb = (db < ay + int'(disp_h)) ? db : ay + int'(disp_h);
            if (!(cl < cr && ct < cb)) begin
                occ = 1'b1;
            end else begin
                for (i = 0; i < cov_count; i++) begin
                    cvl = int'(cov_left[i]);
                    cvt = int'(cov_top[i]);
                    cvw = int'(cov_w[i]);
                    cvh = int'(cov_h[i]);
                    if (!hit && cl >= cvl && cr <= cvl + cvw && ct >= cvt && cb <= cvt + cvh)
                        hit = 1'b1;
                end
                // A full table simply stops growing; that only makes culling rarer.
                if (!hit && d[64] && cov_count < COVER_DEPTH) begin
                    top = (dt < -32768) ? -32768 : dt;
                    cov_left[cov_count] = 16'(dl);
                    cov_top[cov_count]  = 16'(top);
                    cov_w[cov_count]    = 17'(dr - dl);
                    cov_h[cov_count]    = 17'(db - top);
                    cov_count++;
                end
                occ = hit;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            disp_x    = '0;
            disp_y    = '0;
            disp_w    = '0;
            disp_h    = '0;
            shadow    = '0;
            titlebar  = '0;
            cov_count = 0;
            expected_occluded.delete();
            pending   = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                reg_sel = woc_reg_t'(paddr[4:2]);
                case (reg_sel)
                    REG_AREA_X:       disp_x   = pwdata[15:0];
                    REG_AREA_Y:       disp_y   = pwdata[15:0];
                    REG_AREA_WIDTH:   disp_w   = pwdata[14:0];
                    REG_AREA_HEIGHT:  disp_h   = pwdata[14:0];
                    REG_SHADOW_SIZE:  shadow   = pwdata[9:0];
                    REG_TITLE_HEIGHT: titlebar = pwdata[9:0];
                    default: ;
                endcase
            end
            // Results are matched before the new item is queued: a result can never
            // belong to an item accepted at the same edge.
            if (m_tvalid && m_tready) begin
                result_count++;
                if (m_tdata[0])
                    occluded_count++;
                if (expected_occluded.size() == 0) begin
                    if (fail_count < 10)
                        $display("checker: result occluded=%0b with no window waiting at %0t",
                                 m_tdata[0], $realtime);
                    fail_count++;
                end else begin
                    wanted = expected_occluded.pop_front();
                    if (m_tdata[0] !== wanted) begin
                        if (fail_count < 10)
                            $display("checker: occluded expected %0b, got %0b at %0t",
                                     wanted, m_tdata[0], $realtime);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_occlusion(s_tdata, s_tuser[0], predicted);
                expected_occluded = {expected_occluded, predicted};
            end
            pending = expected_occluded.size();
        end
    end

endmodule

FILE: bench/window_occlusion_cull_tb.sv
// Testbench top for the window occlusion cull block: stimulus, register setup and verdict.
`timescale 1ns / 1ps

module window_occlusion_cull_tb;

    import woc_pkg::*;

    localparam int COVER_DEPTH  = woc_pkg::COVER_DEPTH_DEF;
    // Far beyond the slowest correct run: about 1300 items at the longest table walk,
    // with every result held up by random stalls and two long hold-offs.
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 400;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int result_count;
    int occluded_count;

    // Display setup as last written; the window generator aims at this area.
    int cfg_x, cfg_y, cfg_w, cfg_h, cfg_sr, cfg_tb;
    int settings_used;
    int windows_sent;
    int cycle_count;

    // The receiver serves one long hold-off for each request the stimulus raises.
    int   hold_requests;
    int   holds_served;
    // While set, neither side inserts idle cycles.
    logic calm;

    // Opaque windows of the current frame, so later windows can be placed inside them.
    int frame_x[$];
    int frame_y[$];
    int frame_w[$];
    int frame_h[$];

    window_occlusion_cull #(
        .COVER_DEPTH (COVER_DEPTH)
    ) i_dut (.*);

    woc_occlusion_checker #(
        .COVER_DEPTH (COVER_DEPTH)
    ) i_checker (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a run that has not reached its verdict by now has hung.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[window_occlusion_cull] ERROR");
        $finish;
    end

    // Result side. It stalls about 12 percent of the time, and on request it holds
    // m_tready low for a long stretch so that the block fills up and stops taking items.
    initial
    begin
        m_tready     = 1'b0;
        holds_served = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_requests > holds_served)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_served++;
            end
            else
            begin
                m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 12);
            end
        end
    end

    function automatic int clamp16(input int v);
        return (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
    endfunction

    function automatic int clamp15(input int v);
        return (v < 0) ? 0 : ((v > 32767) ? 32767 : v);
    endfunction

    // Register write: setup cycle, then access cycle until pready. Entered at a falling edge.
    task automatic apb_write(input woc_reg_t r, input int v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stop offering items and wait until every predicted result has come back, then
    // leave the block a full table walk of quiet cycles.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (COVER_DEPTH + 8) @(negedge clk);
    endtask

    // Registers are only rewritten while the block is idle.
    task automatic apply_setting(input int x, input int y, input int w, input int h,
                                 input int sr, input int tb);
        drain_results();
        cfg_x  = x;
        cfg_y  = y;
        cfg_w  = w;
        cfg_h  = h;
        cfg_sr = sr;
        cfg_tb = tb;
        apb_write(REG_AREA_X, x & 32'hFFFF);
        apb_write(REG_AREA_Y, y & 32'hFFFF);
        apb_write(REG_AREA_WIDTH, w);
        apb_write(REG_AREA_HEIGHT, h);
        apb_write(REG_SHADOW_SIZE, sr);
        apb_write(REG_TITLE_HEIGHT, tb);
        settings_used++;
    endtask

    // Offer one window item and hold it until the block takes it. Entered at a falling
    // edge; s_tvalid is left high so back-to-back items need no extra assignment.
    task automatic send_window(input logic fs, input int x, input int y, input int w,
                               input int h, input logic tr, input logic vis, input logic op);
        logic [15:0] x16;
        logic [15:0] y16;
        logic [14:0] w15;
        logic [14:0] h15;
        x16 = 16'(clamp16(x));
        y16 = 16'(clamp16(y));
        w15 = 15'(clamp15(w));
        h15 = 15'(clamp15(h));
        while (!calm && $urandom_range(0, 99) < 12)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, op, vis, tr, h15, w15, y16, x16};
        s_tuser  <= fs;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        windows_sent++;
    endtask

    // Random frames: a frame opens with frame_start and holds up to 24 windows, so the
    // table often fills. Many windows nest inside an earlier opaque one to reach the
    // culled path; the rest land in the display area or are raw noise over all bits.
    task automatic run_frames(input int n_items, input int hold_at, input int pause_at);
        int   k, left, r, j, x, y, w, h, span_w, span_h;
        logic fs, tr, vis, op;
        left = 0;
        for (k = 0; k < n_items; k++)
        begin
            if (k == hold_at)
                hold_requests++;
            if (k == pause_at)
                drain_results();
            if (left == 0)
            begin
                left = $urandom_range(1, 24);
                fs = 1'b1;
            end
            else
            begin
                fs = ($urandom_range(0, 99) < 3);
            end
            left--;
            if (fs)
            begin
                frame_x.delete();
                frame_y.delete();
                frame_w.delete();
                frame_h.delete();
            end
            tr  = ($urandom_range(0, 9) == 0);
            vis = ($urandom_range(0, 9) != 0);
            op  = ($urandom_range(0, 9) < 7);
            r   = $urandom_range(0, 99);
            if (r < 40 && frame_x.size() > 0)
            begin
                j = $urandom_range(0, frame_x.size() - 1);
                x = frame_x[j] + $urandom_range(0, frame_w[j] / 2);
                y = frame_y[j] + $urandom_range(0, frame_h[j] / 2);
                w = $urandom_range(0, frame_w[j] - (x - frame_x[j]));
                h = $urandom_range(0, frame_h[j] - (y - frame_y[j]));
            end
            else if (r < 85)
            begin
                span_w = (cfg_w > 0) ? cfg_w : 64;
                span_h = (cfg_h > 0) ? cfg_h : 64;
                w = $urandom_range(0, span_w);
                h = $urandom_range(0, span_h);
                x = cfg_x + $urandom_range(0, span_w) - w / 2;
                y = cfg_y + $urandom_range(0, span_h) - h / 2;
            end
            else
            begin
                x = $urandom_range(0, 65535) - 32768;
                y = $urandom_range(0, 65535) - 32768;
                w = $urandom_range(0, 32767);
                h = $urandom_range(0, 32767);
            end
            x = clamp16(x);
            y = clamp16(y);
            w = clamp15(w);
            h = clamp15(h);
            send_window(fs, x, y, w, h, tr, vis, op);
            if (op && vis && !tr)
            begin
                frame_x = {frame_x, x};
                frame_y = {frame_y, y};
                frame_w = {frame_w, w};
                frame_h = {frame_h, h};
            end
        end
    endtask

    initial
    begin
        int p, x, w, y, h, hold_at, pause_at;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        calm          = 1'b0;
        hold_requests = 0;
        settings_used = 0;
        windows_sent  = 0;
        cfg_x = 0; cfg_y = 0; cfg_w = 0; cfg_h = 0; cfg_sr = 0; cfg_tb = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // After reset the display area is empty, so an untransformed window is culled.
        send_window(1'b1, 10, 10, 100, 100, 1'b0, 1'b1, 1'b1);

        // Small display with decoration: the basic decisions, in their order of priority.
        apply_setting(0, 0, 640, 480, 8, 24);
        send_window(1'b1, 100, 100, 200, 150, 1'b0, 1'b1, 1'b1);  // visible, becomes a cover
        send_window(1'b0, 120, 120, 50, 50, 1'b0, 1'b1, 1'b1);    // inside it: culled
        send_window(1'b0, 120, 120, 50, 50, 1'b1, 1'b1, 1'b1);    // transformed wins
        send_window(1'b0, 120, 120, 50, 50, 1'b0, 1'b0, 1'b1);    // invisible
        send_window(1'b0, 700, 100, 50, 50, 1'b0, 1'b1, 1'b1);    // clipped away entirely
        send_window(1'b0, 250, 100, 200, 50, 1'b0, 1'b1, 1'b0);   // sticks out, translucent

        // Fill the table with disjoint opaque windows, the first of zero size. The next
        // one finds the table full and is not stored, so a copy of it is not culled.
        for (p = 0; p < COVER_DEPTH; p++)
            send_window(p == 0, p * 24, 300, (p == 0) ? 0 : 10, (p == 0) ? 0 : 10,
                        1'b0, 1'b1, 1'b1);
        send_window(1'b0, COVER_DEPTH * 24, 300, 10, 10, 1'b0, 1'b1, 1'b1);
        send_window(1'b0, COVER_DEPTH * 24, 300, 10, 10, 1'b0, 1'b1, 1'b1);
        send_window(1'b0, 0, 300, 0, 0, 1'b0, 1'b1, 1'b1);        // culled by the first
        send_window(1'b1, 0, 300, 0, 0, 1'b0, 1'b1, 1'b1);        // new frame: table empty

        // Extremes: the decorated top falls below the 16-bit range and is clamped.
        apply_setting(-32768, -32768, 32767, 32767, 1023, 1023);
        send_window(1'b1, -32768, -32768, 32767, 32767, 1'b0, 1'b1, 1'b1);
        send_window(1'b0, 32767, 32767, 0, 0, 1'b0, 1'b1, 1'b1);
        send_window(1'b0, -32768, -32768, 100, 100, 1'b0, 1'b1, 1'b1);

        // Random frames under a series of setups, the extremes among them.
        apply_setting(0, 0, 1920, 1080, 16, 32);
        run_frames(127, -1, -1);
        apply_setting(-32768, -32768, 32767, 32767, 1023, 1023);
        run_frames(127, 40, -1);
        apply_setting(32767, 32767, 32767, 32767, 0, 0);
        run_frames(60, -1, -1);
        apply_setting(0, 0, 1, 1, 0, 0);
        run_frames(60, -1, -1);
        for (p = 0; p < 6; p++)
        begin
            if (p == 5)
            begin
                // One setup drawn over the full range of every register.
                x = $urandom_range(0, 65535) - 32768;
                y = $urandom_range(0, 65535) - 32768;
                w = $urandom_range(0, 32767);
                h = $urandom_range(0, 32767);
            end
            else
            begin
                x = $urandom_range(0, 4000) - 2000;
                y = $urandom_range(0, 4000) - 2000;
                w = $urandom_range(1, 4000);
                h = $urandom_range(1, 4000);
            end
            hold_at  = (p == 1) ? 70 : -1;
            pause_at = (p == 3) ? 60 : -1;
            apply_setting(x, y, w, h, $urandom_range(0, 1023), $urandom_range(0, 1023));
            calm = (p == 2);
            run_frames(150, hold_at, pause_at);
            calm = 1'b0;
        end

        drain_results();
        $display("Ran %0d windows under %0d register setups, %0d results seen.",
                 windows_sent, settings_used, result_count);
        $display("%0d windows were culled, %0d mismatches found.", occluded_count, fail_count);
        if (fail_count == 0)
            $display("[window_occlusion_cull] OK");
        else
            $display("[window_occlusion_cull] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/woc_pkg.sv
hdl/woc_ctrl.sv
hdl/woc_datapath.sv
hdl/window_occlusion_cull.sv
bench/woc_occlusion_checker.sv
bench/window_occlusion_cull_tb.sv
